// ===== hw/rtl/ipv4_text_to_bytes_parser_core_macros.svh =====
// Assertion macros shared by the IPv4 text parser RTL.
// Each macro samples on the rising clock edge and is disabled while reset is high.
`ifndef IPV4_TEXT_TO_BYTES_PARSER_CORE_MACROS_SVH
`define IPV4_TEXT_TO_BYTES_PARSER_CORE_MACROS_SVH

// The consequence must hold in the same cycle as the trigger.
`define IPV4TB_ASSERT_SAME(label, trig, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cons)) \
      else $error(msg);

// The consequence must hold in the cycle after the trigger.
`define IPV4TB_ASSERT_NEXT(label, trig, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/ipv4tb_pkg.sv =====
// Shared types and constants for the IPv4 dotted-text parser.
// Used by every module of the block; depends on nothing else.
package ipv4tb_pkg;

   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;
   localparam logic [7:0] CHAR_DOT  = 8'h2E;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_SYNTAX   = 2'd1;
   localparam logic [1:0] STATUS_NOT_IPV4 = 2'd2;

   localparam logic [2:0] DOT_LIMIT = 3'd4;
   localparam logic [2:0] BYTES_ALL = 3'd4;

   localparam int unsigned QUEUE_DEPTH = 4;

   typedef struct packed {
      logic [7:0] text_char;
      logic       last_char;
   } req_type;

   typedef struct packed {
      logic [1:0]  parse_status;
      logic [2:0]  bytes_written;
      logic [31:0] address_value;
   } rsp_type;

   // One character after classification.
   typedef struct packed {
      logic       is_digit;
      logic       is_dot;
      logic [3:0] digit;
      logic       last_char;
   } token_type;

endpackage

// ===== hw/rtl/ipv4tb_front.sv =====
// Input stage: accepts characters and classifies them into tokens.
// Uses ipv4tb_pkg; feeds ipv4tb_queue.
module ipv4tb_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  ipv4tb_pkg::req_type   req_data,
   input  logic                  queue_full,
   output logic                  push,
   output ipv4tb_pkg::token_type push_token
);

   logic                  tok_valid_ff, tok_valid_in;
   ipv4tb_pkg::token_type tok_ff, tok_in;
   logic                  accept;

   always_comb begin
      push      = tok_valid_ff && !queue_full;
      req_stall = tok_valid_ff && queue_full;
      accept    = req_valid && !req_stall;

      tok_in.is_digit  = (req_data.text_char >= ipv4tb_pkg::CHAR_ZERO) &&
                         (req_data.text_char <= ipv4tb_pkg::CHAR_NINE);
      tok_in.is_dot    = (req_data.text_char == ipv4tb_pkg::CHAR_DOT);
      tok_in.digit     = 4'(req_data.text_char - ipv4tb_pkg::CHAR_ZERO);
      tok_in.last_char = req_data.last_char;

      if (accept) begin
         tok_valid_in = 1'b1;
      end else if (push) begin
         tok_valid_in = 1'b0;
      end else begin
         tok_valid_in = tok_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_valid_ff <= 1'b0;
      end else begin
         tok_valid_ff <= tok_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         tok_ff <= tok_in;
      end
   end

   assign push_token = tok_ff;

endmodule

// ===== hw/rtl/ipv4tb_queue.sv =====
// Short token queue between the classifier and the parser back end.
// Uses ipv4tb_pkg for the token type.
module ipv4tb_queue #(
   parameter int unsigned DEPTH = ipv4tb_pkg::QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  ipv4tb_pkg::token_type push_token,
   output logic                  full,
   input  logic                  pop,
   output ipv4tb_pkg::token_type pop_token,
   output logic                  not_empty
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   ipv4tb_pkg::token_type mem_ff [DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  do_push, do_pop;

   always_comb begin
      full      = (count_ff == CNT_W'(DEPTH));
      not_empty = (count_ff != '0);
      do_push   = push && !full;
      do_pop    = pop && not_empty;

      wr_ptr_in = wr_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      rd_ptr_in = rd_ptr_ff;
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end

      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_token;
      end
   end

   assign pop_token = mem_ff[rd_ptr_ff];

endmodule

// ===== hw/rtl/ipv4tb_back.sv =====
// Parser back end: accumulates components, counts dots and builds the result word.
// Uses ipv4tb_pkg and the assertion macros; reads tokens from ipv4tb_queue.
`include "ipv4_text_to_bytes_parser_core_macros.svh"

module ipv4tb_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  tok_valid,
   input  ipv4tb_pkg::token_type tok,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output ipv4tb_pkg::rsp_type   rsp_data
);

   logic [31:0] acc_ff, acc_in, acc_step;
   logic [23:0] bytes_ff, bytes_in, bytes_step;
   logic [1:0]  cnt_ff, cnt_in, cnt_step;
   logic [2:0]  dot_ff, dot_in, dot_step;
   logic        err_ff, err_in, err_step;
   logic        start_ff, start_in, start_step;

   logic                rsp_valid_ff, rsp_valid_in;
   ipv4tb_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic [31:0]         head, tail;
   logic                finish;

   always_comb begin
      // A character that ends an address needs room in the result register.
      pop    = tok_valid && (!tok.last_char || !rsp_valid_ff || !rsp_stall);
      finish = pop && tok.last_char;

      dot_step = dot_ff;
      if (tok.is_dot && (dot_ff < ipv4tb_pkg::DOT_LIMIT)) begin
         dot_step = dot_ff + 3'd1;
      end

      acc_step   = acc_ff;
      bytes_step = bytes_ff;
      cnt_step   = cnt_ff;
      err_step   = err_ff;
      start_step = start_ff;
      if (!err_ff) begin
         priority if (tok.is_digit) begin
            acc_step   = (acc_ff << 3) + (acc_ff << 1) + {28'd0, tok.digit};
            start_step = 1'b0;
         end else if (tok.is_dot && !start_ff) begin
            if (cnt_ff != 2'd3) begin
               bytes_step = {bytes_ff[15:0], acc_ff[7:0]};
               cnt_step   = cnt_ff + 2'd1;
            end
            acc_step   = '0;
            start_step = 1'b1;
         end else begin
            err_step = 1'b1;
         end
      end

      // The last component fills every byte not taken by a stored one.
      unique case (cnt_step)
         2'd0: begin
            head = '0;
            tail = acc_step;
         end
         2'd1: begin
            head = {bytes_step[7:0], 24'd0};
            tail = {8'd0, acc_step[23:0]};
         end
         2'd2: begin
            head = {bytes_step[15:0], 16'd0};
            tail = {16'd0, acc_step[15:0]};
         end
         default: begin
            head = {bytes_step[23:0], 8'd0};
            tail = {24'd0, acc_step[7:0]};
         end
      endcase

      priority if (dot_step > 3'd3) begin
         rsp_data_in.parse_status  = ipv4tb_pkg::STATUS_NOT_IPV4;
         rsp_data_in.bytes_written = '0;
         rsp_data_in.address_value = '0;
      end else if (err_step || start_step) begin
         rsp_data_in.parse_status  = ipv4tb_pkg::STATUS_SYNTAX;
         rsp_data_in.bytes_written = {1'b0, cnt_step};
         rsp_data_in.address_value = head;
      end else begin
         rsp_data_in.parse_status  = ipv4tb_pkg::STATUS_OK;
         rsp_data_in.bytes_written = ipv4tb_pkg::BYTES_ALL;
         rsp_data_in.address_value = head | tail;
      end

      acc_in   = acc_ff;
      bytes_in = bytes_ff;
      cnt_in   = cnt_ff;
      dot_in   = dot_ff;
      err_in   = err_ff;
      start_in = start_ff;
      if (finish) begin
         acc_in   = '0;
         bytes_in = '0;
         cnt_in   = '0;
         dot_in   = '0;
         err_in   = 1'b0;
         start_in = 1'b1;
      end else if (pop) begin
         acc_in   = acc_step;
         bytes_in = bytes_step;
         cnt_in   = cnt_step;
         dot_in   = dot_step;
         err_in   = err_step;
         start_in = start_step;
      end

      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         bytes_ff     <= '0;
         cnt_ff       <= '0;
         dot_ff       <= '0;
         err_ff       <= 1'b0;
         start_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         bytes_ff     <= bytes_in;
         cnt_ff       <= cnt_in;
         dot_ff       <= dot_in;
         err_ff       <= err_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `IPV4TB_ASSERT_NEXT(a_result_after_last, finish, rsp_valid_ff, "final character gave no result")
   `IPV4TB_ASSERT_NEXT(a_state_cleared, finish, (dot_ff == '0) && start_ff && (cnt_ff == '0) && !err_ff && (acc_ff == '0), "parser state not cleared after an address")
   `IPV4TB_ASSERT_SAME(a_not_ipv4_empty, rsp_valid_ff && (rsp_data_ff.parse_status == ipv4tb_pkg::STATUS_NOT_IPV4), (rsp_data_ff.bytes_written == '0) && (rsp_data_ff.address_value == '0), "too many dots but bytes reported")
   `IPV4TB_ASSERT_SAME(a_ok_all_bytes, rsp_valid_ff && (rsp_data_ff.parse_status == ipv4tb_pkg::STATUS_OK), rsp_data_ff.bytes_written == ipv4tb_pkg::BYTES_ALL, "good address without four bytes")

endmodule

// ===== hw/rtl/ipv4_text_to_bytes_parser_core.sv =====
// IPv4 dotted-text parser, top level.
// Instantiates ipv4tb_front, ipv4tb_queue and ipv4tb_back; types from ipv4tb_pkg.
//
// Usage:
// The req channel takes one ASCII character per word, with last_char set on the
// final character of an address. The rsp channel gives one word per address:
// parse_status, bytes_written and the address packed big-endian.
// A word is moved on a rising edge with valid high and stall low.
// Throughput is one character per cycle while req_stall is low; the accumulator update (a times-ten
// shift-add) in the back end is the one step per character.
// After the final character is accepted, the result passes the classifier register,
// the token queue and the result register before it is presented.
// While rsp_stall is high the result is held and the back end still parses
// characters of the next address; the final character waits in the queue, and
// req_stall rises once the queue of QUEUE_DEPTH tokens and the classifier
// register are full.
// Reset (synchronous, active high) empties the queue, drops any result and
// returns the parser to the start of an address; it is ready the next cycle.
module ipv4_text_to_bytes_parser_core #(
   parameter int unsigned QUEUE_DEPTH = ipv4tb_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  ipv4tb_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output ipv4tb_pkg::rsp_type rsp_data
);

   logic                  queue_full;
   logic                  push;
   ipv4tb_pkg::token_type push_token;
   logic                  pop;
   ipv4tb_pkg::token_type pop_token;
   logic                  not_empty;

   ipv4tb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .queue_full (queue_full),
      .push       (push),
      .push_token (push_token)
   );

   ipv4tb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_token (push_token),
      .full       (queue_full),
      .pop        (pop),
      .pop_token  (pop_token),
      .not_empty  (not_empty)
   );

   ipv4tb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .tok_valid (not_empty),
      .tok       (pop_token),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for ipv4_text_to_bytes_parser_core: address text goes in
// one character per word and every result word is checked against a table entry or a local parser.
// Depends on ipv4tb_pkg and the core RTL only.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_CHARS = 1950;
   localparam int LONG_HOLD = 300;
   localparam int MAX_REPORTS = 10;
   localparam ipv4tb_pkg::rsp_type NO_RSP = '0;

   typedef struct packed {
      logic [7:0]          text_char;
      logic                last_char;
      logic                typed;
      ipv4tb_pkg::rsp_type want;
   } dir_row_type;

   typedef struct {
      logic                typed;
      ipv4tb_pkg::rsp_type want;
   } rsp_note_type;

   localparam int DIR_ROWS = 24;
   // The opening rows carry their result where it is plain; the rest go to the parser.
   localparam dir_row_type DIR_TABLE [DIR_ROWS] = '{
      '{"1", 1'b0, 1'b0, NO_RSP},
      '{ipv4tb_pkg::CHAR_DOT, 1'b0, 1'b0, NO_RSP},
      '{"2", 1'b0, 1'b0, NO_RSP},
      '{ipv4tb_pkg::CHAR_DOT, 1'b0, 1'b0, NO_RSP},
      '{"3", 1'b0, 1'b0, NO_RSP},
      '{ipv4tb_pkg::CHAR_DOT, 1'b0, 1'b0, NO_RSP},
      '{"4", 1'b1, 1'b1, '{ipv4tb_pkg::STATUS_OK, ipv4tb_pkg::BYTES_ALL, 32'h0102_0304}},
      '{ipv4tb_pkg::CHAR_DOT, 1'b1, 1'b1, '{ipv4tb_pkg::STATUS_SYNTAX, 3'd0, 32'h0}},
      '{ipv4tb_pkg::CHAR_DOT, 1'b0, 1'b0, NO_RSP},
      '{ipv4tb_pkg::CHAR_DOT, 1'b0, 1'b0, NO_RSP},
      '{ipv4tb_pkg::CHAR_DOT, 1'b0, 1'b0, NO_RSP},
      '{ipv4tb_pkg::CHAR_DOT, 1'b1, 1'b1, '{ipv4tb_pkg::STATUS_NOT_IPV4, 3'd0, 32'h0}},
      '{8'hFF, 1'b1, 1'b1, '{ipv4tb_pkg::STATUS_SYNTAX, 3'd0, 32'h0}},
      '{8'h00, 1'b1, 1'b1, '{ipv4tb_pkg::STATUS_SYNTAX, 3'd0, 32'h0}},
      '{"9", 1'b0, 1'b0, NO_RSP},
      '{ipv4tb_pkg::CHAR_DOT, 1'b1, 1'b1, '{ipv4tb_pkg::STATUS_SYNTAX, 3'd1, 32'h0900_0000}},
      '{"3", 1'b0, 1'b0, NO_RSP},
      '{"0", 1'b0, 1'b0, NO_RSP},
      '{"0", 1'b1, 1'b0, NO_RSP},
      '{"1", 1'b0, 1'b0, NO_RSP},
      '{ipv4tb_pkg::CHAR_DOT, 1'b0, 1'b0, NO_RSP},
      '{"2", 1'b0, 1'b0, NO_RSP},
      '{ipv4tb_pkg::CHAR_DOT, 1'b0, 1'b0, NO_RSP},
      '{"3", 1'b1, 1'b0, NO_RSP}
   };

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   ipv4tb_pkg::req_type req_data = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   ipv4tb_pkg::rsp_type rsp_data;

   // Parser state mirrored from the block.
   logic [31:0] acc;
   logic [23:0] kept_bytes;
   logic [1:0]  kept_count;
   logic [2:0]  dots_seen;
   logic        parse_failed;
   logic        comp_start;

   ipv4tb_pkg::rsp_type expected_addrs[$];
   rsp_note_type        result_notes[$];
   logic [7:0]          addr_text[$];
   int                  fail_count = 0;
   logic                burst = 1'b0;
   logic                long_hold_armed = 1'b0;

   ipv4_text_to_bytes_parser_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic clear_parse();
      acc = '0;
      kept_bytes = '0;
      kept_count = '0;
      dots_seen = '0;
      parse_failed = 1'b0;
      comp_start = 1'b1;
   endtask

   task automatic parse_char(input ipv4tb_pkg::req_type w, output logic has_rsp,
                             output ipv4tb_pkg::rsp_type r);
      logic        is_dot;
      logic        is_digit;
      logic [31:0] head;
      logic [31:0] mask;
      is_dot = (w.text_char == ipv4tb_pkg::CHAR_DOT);
      is_digit = (w.text_char >= ipv4tb_pkg::CHAR_ZERO) &&
                 (w.text_char <= ipv4tb_pkg::CHAR_NINE);
      if (is_dot && dots_seen < ipv4tb_pkg::DOT_LIMIT)
         dots_seen++;
      // After the first error only the dot count keeps moving.
      if (!parse_failed) begin
         if (is_digit) begin
            acc = acc * 32'd10 + 32'(w.text_char - ipv4tb_pkg::CHAR_ZERO);
            comp_start = 1'b0;
         end else if (is_dot && !comp_start) begin
            if (kept_count < 2'd3) begin
               kept_bytes = {kept_bytes[15:0], acc[7:0]};
               kept_count++;
            end
            acc = '0;
            comp_start = 1'b1;
         end else begin
            parse_failed = 1'b1;
         end
      end
      has_rsp = w.last_char;
      r = NO_RSP;
      if (w.last_char) begin
         head = {kept_bytes, 8'h00} << (8 * (3 - int'(kept_count)));
         mask = 32'hFFFF_FFFF >> (8 * int'(kept_count));
         if (dots_seen == ipv4tb_pkg::DOT_LIMIT)
            r = '{ipv4tb_pkg::STATUS_NOT_IPV4, 3'd0, 32'd0};
         else if (parse_failed || comp_start)
            r = '{ipv4tb_pkg::STATUS_SYNTAX, {1'b0, kept_count}, head};
         else
            // The final component fills every byte that is still free.
            r = '{ipv4tb_pkg::STATUS_OK, ipv4tb_pkg::BYTES_ALL, head | (acc & mask)};
         clear_parse();
      end
   endtask

   task automatic log_failure(input string what, input ipv4tb_pkg::rsp_type want,
                              input ipv4tb_pkg::rsp_type got);
      fail_count++;
      if (fail_count <= MAX_REPORTS)
         $display(
            "%0t ns %s: expected status %0d bytes %0d addr %h, got status %0d bytes %0d addr %h",
            $time, what, want.parse_status, want.bytes_written, want.address_value,
            got.parse_status, got.bytes_written, got.address_value);
   endtask

   always @(posedge clock) begin : word_checker
      logic                has_rsp;
      ipv4tb_pkg::rsp_type want;
      rsp_note_type        note;
      if (reset) begin
         clear_parse();
      end else begin
         if (req_valid && !req_stall) begin
            parse_char(req_data, has_rsp, want);
            if (has_rsp) begin
               note = result_notes.pop_front();
               expected_addrs.push_back(note.typed ? note.want : want);
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_addrs.size() == 0) begin
               log_failure("unexpected word", NO_RSP, rsp_data);
            end else begin
               want = expected_addrs.pop_front();
               if (rsp_data.parse_status !== want.parse_status ||
                   rsp_data.bytes_written !== want.bytes_written ||
                   rsp_data.address_value !== want.address_value)
                  log_failure("mismatch", want, rsp_data);
            end
         end
      end
   end

   function automatic int idle_cycles();
      int r;
      if (burst)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(5, 25);
   endfunction

   task automatic send_char(input ipv4tb_pkg::req_type w);
      int gap;
      gap = idle_cycles();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   // Mostly well-formed dotted text with random components; some noise and broken forms.
   task automatic build_address();
      int          kind;
      int          parts;
      int          r;
      int          zeros;
      logic [63:0] v;
      logic [7:0]  digits[$];
      addr_text.delete();
      kind = $urandom_range(0, 99);
      if (kind < 12) begin
         repeat ($urandom_range(1, 6))
            addr_text.push_back(8'($urandom_range(0, 255)));
         return;
      end
      parts = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(5, 6);
      for (int p = 0; p < parts; p++) begin
         if (p > 0)
            addr_text.push_back(ipv4tb_pkg::CHAR_DOT);
         r = $urandom_range(0, 19);
         if (r < 12)
            v = 64'($urandom_range(0, 255));
         else if (r < 15)
            v = 64'($urandom_range(0, 65535));
         else if (r < 18)
            v = 64'($urandom);
         else
            v = {$urandom, $urandom} >> $urandom_range(0, 30);
         digits.delete();
         do begin
            digits.push_front(ipv4tb_pkg::CHAR_ZERO + 8'(v % 10));
            v = v / 10;
         end while (v != 0);
         zeros = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0;
         repeat (zeros)
            addr_text.push_back(ipv4tb_pkg::CHAR_ZERO);
         foreach (digits[i])
            addr_text.push_back(digits[i]);
      end
      if (kind < 30) begin
         case ($urandom_range(0, 3))
            0: addr_text[$urandom_range(0, addr_text.size() - 1)] = 8'($urandom_range(0, 255));
            1: addr_text.insert($urandom_range(0, addr_text.size()), ipv4tb_pkg::CHAR_DOT);
            2: addr_text.push_back(ipv4tb_pkg::CHAR_DOT);
            default: addr_text.push_front(ipv4tb_pkg::CHAR_DOT);
         endcase
      end
   endtask

   // Result side: free stretches, short stalls, the odd long one, and one hold-off
   // long enough to back the block up into its input.
   initial begin : rsp_pacer
      int   r;
      int   n;
      logic level;
      @(posedge clock);
      forever begin
         if (long_hold_armed) begin
            long_hold_armed = 1'b0;
            level = 1'b1;
            n = LONG_HOLD;
         end else begin
            r = $urandom_range(0, 9);
            if (r < 4) begin
               level = 1'b0;
               n = $urandom_range(1, 30);
            end else if (r < 9) begin
               level = 1'b1;
               n = $urandom_range(1, 3);
            end else begin
               level = 1'b1;
               n = $urandom_range(10, 60);
            end
         end
         rsp_stall <= level;
         repeat (n) @(posedge clock);
      end
   end

   initial begin : char_source
      dir_row_type  row;
      rsp_note_type note;
      int           sent;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int i = 0; i < DIR_ROWS; i++) begin
         row = DIR_TABLE[i];
         if (row.last_char) begin
            note.typed = row.typed;
            note.want = row.want;
            result_notes.push_back(note);
         end
         send_char('{row.text_char, row.last_char});
      end
      long_hold_armed = 1'b1;
      sent = 0;
      while (sent < RANDOM_CHARS) begin
         build_address();
         burst = ($urandom_range(0, 3) == 0);
         foreach (addr_text[k]) begin
            if (k == addr_text.size() - 1) begin
               note.typed = 1'b0;
               note.want = NO_RSP;
               result_notes.push_back(note);
            end
            send_char('{addr_text[k], k == addr_text.size() - 1});
         end
         sent += addr_text.size();
      end
      req_valid <= 1'b0;
      while (expected_addrs.size() != 0 || result_notes.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("PASS ipv4_text_to_bytes_parser_core");
      else
         $display("FAIL ipv4_text_to_bytes_parser_core");
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("FAIL ipv4_text_to_bytes_parser_core");
      $finish;
   end

endmodule

// ===== ipv4_text_to_bytes_parser_core.f =====
+incdir+hw/rtl
hw/rtl/ipv4tb_pkg.sv
hw/rtl/ipv4tb_front.sv
hw/rtl/ipv4tb_queue.sv
hw/rtl/ipv4tb_back.sv
hw/rtl/ipv4_text_to_bytes_parser_core.sv
dv/tb.sv
